[hdl/lgts_pkg.sv]
// Shared types, constants and functions of the lattice gas torus simulator.
package lgts_pkg;

	// Default storage dimensions
	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 64;

	// Particle direction bits
	localparam logic [3:0] DOWN  = 4'h1;
	localparam logic [3:0] UP    = 4'h2;
	localparam logic [3:0] LEFT  = 4'h4;
	localparam logic [3:0] RIGHT = 4'h8;

	// Command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_RUN   = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_ROW_COUNT  = 2'd0;
	localparam logic [1:0] CFG_COL_COUNT  = 2'd1;
	localparam logic [1:0] CFG_STEP_COUNT = 2'd2;

	localparam int CFG_DATA_W = 16;

	typedef struct packed {
		logic [1:0] command;
		logic [5:0] row;
		logic [5:0] col;
		logic [3:0] cell_in;
	} in_word_t;

	typedef struct packed {
		logic [3:0] cell_out;
		logic [1:0] done_kind;
	} out_word_t;

	// Which neighbor of the current cell a read or capture concerns
	typedef enum logic [1:0] {
		NB_LEFT  = 2'd0,
		NB_RIGHT = 2'd1,
		NB_UP    = 2'd2,
		NB_DOWN  = 2'd3
	} nbr_t;

	typedef struct packed {
		logic host_wr;
		logic host_rd;
		logic load_run;
		logic rd_en;
		nbr_t rd_nbr;
		logic cap_en;
		nbr_t cap_nbr;
		logic write_cell;
		logic next_step;
		logic copy_rd;
		logic copy_wr;
		logic post_run;
	} ctrl_cmd_t;

	typedef struct packed {
		logic s1_free;
		logic last_cell;
		logic last_step;
		logic zero_steps;
	} dp_status_t;

	// Particle that a neighbor sends into the current cell
	function automatic logic [3:0] nbr_bits(input nbr_t nb, input logic [3:0] v);
		logic [3:0] r;
		unique case (nb)
			NB_LEFT:  r = v & RIGHT;
			NB_RIGHT: r = v & LEFT;
			NB_UP:    r = v & DOWN;
			NB_DOWN:  r = v & UP;
			default:  r = 4'h0;
		endcase
		return r;
	endfunction

	// Head-on pairs rotate by ninety degrees, right-angle pairs swap their left and right bit, everything else passes
	function automatic logic [3:0] collide(input logic [3:0] v);
		logic [3:0] r;
		unique case (v)
			4'h3:    r = 4'hC;
			4'hC:    r = 4'h3;
			4'hA:    r = 4'h6;
			4'h9:    r = 4'h5;
			4'h6:    r = 4'hA;
			4'h5:    r = 4'h9;
			default: r = v;
		endcase
		return r;
	endfunction

endpackage

[hdl/lgts_ctrl.sv]
// Sequencer of the lattice gas simulator: host commands and the per-cell run schedule.
module lgts_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [1:0]            in_command,
	output logic                  in_ready,
	input  lgts_pkg::dp_status_t  st,
	output lgts_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_LOAD = 10'b00_0000_0010,
		S_N0   = 10'b00_0000_0100,
		S_N1   = 10'b00_0000_1000,
		S_N2   = 10'b00_0001_0000,
		S_N3   = 10'b00_0010_0000,
		S_WR   = 10'b00_0100_0000,
		S_CR   = 10'b00_1000_0000,
		S_CW   = 10'b01_0000_0000,
		S_DONE = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = st.s1_free;
				if (in_valid && st.s1_free) begin
					unique case (in_command)
						lgts_pkg::CMD_WRITE: cmd.host_wr = 1'b1;
						lgts_pkg::CMD_READ:  cmd.host_rd = 1'b1;
						lgts_pkg::CMD_RUN: begin
							cmd.load_run = 1'b1;
							state_d      = S_LOAD;
						end
						default: ;
					endcase
				end
			end
			S_LOAD: begin
				state_d = st.zero_steps ? S_DONE : S_N0;
			end
			S_N0: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_nbr = lgts_pkg::NB_LEFT;
				state_d    = S_N1;
			end
			S_N1: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_nbr  = lgts_pkg::NB_RIGHT;
				cmd.cap_en  = 1'b1;
				cmd.cap_nbr = lgts_pkg::NB_LEFT;
				state_d     = S_N2;
			end
			S_N2: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_nbr  = lgts_pkg::NB_UP;
				cmd.cap_en  = 1'b1;
				cmd.cap_nbr = lgts_pkg::NB_RIGHT;
				state_d     = S_N3;
			end
			S_N3: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_nbr  = lgts_pkg::NB_DOWN;
				cmd.cap_en  = 1'b1;
				cmd.cap_nbr = lgts_pkg::NB_UP;
				state_d     = S_WR;
			end
			S_WR: begin
				cmd.write_cell = 1'b1;
				cmd.cap_nbr    = lgts_pkg::NB_DOWN;
				if (st.last_cell && st.last_step) begin
					state_d = S_CR;
				end else begin
					cmd.next_step = st.last_cell;
					state_d       = S_N0;
				end
			end
			// Copy the final grid of the active region into the other bank
			S_CR: begin
				cmd.copy_rd = 1'b1;
				state_d     = S_CW;
			end
			S_CW: begin
				cmd.copy_wr = 1'b1;
				state_d     = st.last_cell ? S_DONE : S_CR;
			end
			S_DONE: begin
				if (st.s1_free) begin
					cmd.post_run = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[hdl/lgts_datapath.sv]
// Grid banks, cell walk counters, neighbor gather and result register of the simulator.
module lgts_datapath #(
	parameter int MAX_ROWS = lgts_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = lgts_pkg::MAX_COLS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lgts_pkg::in_word_t   in_data,
	input  logic [6:0]           row_count,
	input  logic [6:0]           col_count,
	input  logic [15:0]          step_count,
	input  lgts_pkg::ctrl_cmd_t  cmd,
	output lgts_pkg::dp_status_t st,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lgts_pkg::out_word_t  out_data
);

	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int AW    = RW + CW;
	localparam int DEPTH = 1 << AW;

	logic [3:0] bank0 [DEPTH];
	logic [3:0] bank1 [DEPTH];

	logic          sel_q;          // bank holding the current grid
	logic [RW-1:0] i_q, rows_m1_q;
	logic [CW-1:0] j_q, cols_m1_q;
	logic [15:0]   steps_q;
	logic [3:0]    acc_q;
	logic [3:0]    rd0_q, rd1_q;
	logic [3:0]    rdata;

	logic          s1_valid_q, s1_inside_q;
	logic [1:0]    s1_kind_q;
	logic          out_valid_q;
	lgts_pkg::out_word_t out_q;
	logic          out_adv;

	logic          in_store;
	logic [AW-1:0] host_addr, cell_addr, nbr_addr, raddr, waddr;
	logic [RW-1:0] i_up, i_dn, nb_i;
	logic [CW-1:0] j_lf, j_rt, nb_j;
	logic [3:0]    wval, wdata;
	logic          we0, we1;
	logic [RW-1:0] rows_m1_d;
	logic [CW-1:0] cols_m1_d;

	assign in_store  = (32'(in_data.row) < MAX_ROWS) && (32'(in_data.col) < MAX_COLS);
	assign host_addr = {RW'(in_data.row), CW'(in_data.col)};
	assign cell_addr = {i_q, j_q};

	// Wrapped neighbor coordinates inside the active region
	assign i_up = (i_q == '0) ? rows_m1_q : i_q - 1'b1;
	assign i_dn = (i_q == rows_m1_q) ? '0 : i_q + 1'b1;
	assign j_lf = (j_q == '0) ? cols_m1_q : j_q - 1'b1;
	assign j_rt = (j_q == cols_m1_q) ? '0 : j_q + 1'b1;

	always_comb begin
		nb_i = i_q;
		nb_j = j_q;
		unique case (cmd.rd_nbr)
			lgts_pkg::NB_LEFT:  nb_j = j_lf;
			lgts_pkg::NB_RIGHT: nb_j = j_rt;
			lgts_pkg::NB_UP:    nb_i = i_up;
			lgts_pkg::NB_DOWN:  nb_i = i_dn;
			default: ;
		endcase
	end

	assign nbr_addr = {nb_i, nb_j};
	assign raddr    = cmd.host_rd ? host_addr : (cmd.copy_rd ? cell_addr : nbr_addr);
	assign rdata    = sel_q ? rd1_q : rd0_q;

	// Down neighbor arrives last and joins the gathered bits directly
	assign wval  = lgts_pkg::collide(acc_q | lgts_pkg::nbr_bits(cmd.cap_nbr, rdata));
	assign waddr = cmd.host_wr ? host_addr : cell_addr;
	assign wdata = cmd.host_wr ? in_data.cell_in : (cmd.copy_wr ? rdata : wval);
	// Host writes land in both banks; a step or the closing copy writes the idle bank
	assign we0   = (cmd.host_wr && in_store) || ((cmd.write_cell || cmd.copy_wr) && sel_q);
	assign we1   = (cmd.host_wr && in_store) || ((cmd.write_cell || cmd.copy_wr) && !sel_q);

	always_ff @(posedge clk) begin
		if (we0) begin
			bank0[waddr] <= wdata;
		end
		if (cmd.rd_en || cmd.host_rd || cmd.copy_rd) begin
			rd0_q <= bank0[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we1) begin
			bank1[waddr] <= wdata;
		end
		if (cmd.rd_en || cmd.host_rd || cmd.copy_rd) begin
			rd1_q <= bank1[raddr];
		end
	end

	// Active dimensions saturated to 1..MAX
	always_comb begin
		if (row_count == 7'd0) begin
			rows_m1_d = '0;
		end else if (32'(row_count) > MAX_ROWS) begin
			rows_m1_d = RW'(MAX_ROWS - 1);
		end else begin
			rows_m1_d = RW'(row_count - 7'd1);
		end
		if (col_count == 7'd0) begin
			cols_m1_d = '0;
		end else if (32'(col_count) > MAX_COLS) begin
			cols_m1_d = CW'(MAX_COLS - 1);
		end else begin
			cols_m1_d = CW'(col_count - 7'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_run) begin
			rows_m1_q <= rows_m1_d;
			cols_m1_q <= cols_m1_d;
			steps_q   <= step_count;
			i_q       <= '0;
			j_q       <= '0;
		end else if (cmd.write_cell || cmd.copy_wr) begin
			if (j_q == cols_m1_q) begin
				j_q <= '0;
				i_q <= i_dn;
			end else begin
				j_q <= j_rt;
			end
			if (cmd.next_step) begin
				steps_q <= steps_q - 16'd1;
			end
		end
		if (cmd.cap_en) begin
			if (cmd.cap_nbr == lgts_pkg::NB_LEFT) begin
				acc_q <= lgts_pkg::nbr_bits(cmd.cap_nbr, rdata);
			end else begin
				acc_q <= acc_q | lgts_pkg::nbr_bits(cmd.cap_nbr, rdata);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (cmd.next_step || (cmd.write_cell && st.last_cell)) begin
			sel_q <= !sel_q;
		end
	end

	// Result stage: s1 waits on the registered read, then the output word
	assign out_adv = s1_valid_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.host_wr || cmd.host_rd || cmd.post_run) begin
				s1_valid_q <= 1'b1;
			end else if (out_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (out_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.host_wr || cmd.host_rd || cmd.post_run) begin
			s1_inside_q <= in_store;
			s1_kind_q   <= cmd.host_wr ? lgts_pkg::CMD_WRITE :
			               cmd.host_rd ? lgts_pkg::CMD_READ : lgts_pkg::CMD_RUN;
		end
		if (out_adv) begin
			out_q.cell_out  <= (s1_kind_q == lgts_pkg::CMD_READ && s1_inside_q) ? rdata : 4'h0;
			out_q.done_kind <= s1_kind_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

	assign st.s1_free    = !s1_valid_q || out_adv;
	assign st.last_cell  = (i_q == rows_m1_q) && (j_q == cols_m1_q);
	assign st.last_step  = (steps_q == 16'd1);
	assign st.zero_steps = (steps_q == 16'd0);

endmodule

[hdl/lattice_gas_torus_sim.sv]
// Top level of the lattice gas torus simulator: config registers, sequencer and datapath.
//
// Channel  Dir  Handshake           Word
// in       in   in_valid/in_ready   in_word_t: command, row, col, cell_in
// out      out  out_valid/out_ready out_word_t: cell_out, done_kind
// cfg      in   cfg_we (no wait)    cfg_index selects, cfg_wdata carries the value
//
// Cell write and cell read words go one per cycle while out_ready keeps up; a read answer
// passes through the s1 stage and then the output register. Each step of a run visits every
// cell with four neighbor reads through the single read port of the grid bank plus one
// write; then a read and a write per cell copy the final grid over (none with step_count 0).
// No input word is taken during a run. Output is registered with one stage in front of it,
// so one more input word is taken while a result waits for out_ready; then in_ready drops.
// Reset clears control only; grid contents stay undefined until written, no clear pass.
//
// Grid is held in two banks (current and next) that swap after each step. Host writes
// land in both banks, and a run ends by copying its active region into the idle bank,
// so both banks agree whenever the block is idle.
module lattice_gas_torus_sim #(
	parameter int MAX_ROWS = lgts_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = lgts_pkg::MAX_COLS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  lgts_pkg::in_word_t               in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output lgts_pkg::out_word_t              out_data,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [lgts_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	logic [6:0]  row_count_q;
	logic [6:0]  col_count_q;
	logic [15:0] step_count_q;

	lgts_pkg::ctrl_cmd_t  cmd;
	lgts_pkg::dp_status_t st;

	// Config registers; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q  <= 7'd64;
			col_count_q  <= 7'd64;
			step_count_q <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lgts_pkg::CFG_ROW_COUNT:  row_count_q  <= cfg_wdata[6:0];
				lgts_pkg::CFG_COL_COUNT:  col_count_q  <= cfg_wdata[6:0];
				lgts_pkg::CFG_STEP_COUNT: step_count_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	lgts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_command (in_data.command),
		.in_ready   (in_ready),
		.st         (st),
		.cmd        (cmd)
	);

	lgts_datapath #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (in_data),
		.row_count  (row_count_q),
		.col_count  (col_count_q),
		.step_count (step_count_q),
		.cmd        (cmd),
		.st         (st),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
